### hdl/dpcm_up_pkg.sv
package dpcm_up_pkg;

    // Pixel and configuration widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 13;
    localparam int STEP_W     = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int RAW_CNT_W  = 4;
    localparam int RUN_W      = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP = 1'b1;

    // Reset values of the configuration registers
    localparam logic [ROW_W-1:0]  ROW_WIDTH_RST  = 13'd512;
    localparam logic [STEP_W-1:0] QUANT_STEP_RST = 8'd15;

    // Raw first pixel of a row is this many bits
    localparam logic [RAW_CNT_W-1:0] RAW_BITS = 4'd8;
    // Run counter saturation value
    localparam logic [RUN_W-1:0]     RUN_MAX  = 8'd255;

    typedef struct packed {
        logic [ROW_W-1:0]  row_width;
        logic [STEP_W-1:0] quant_step;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_last;
    } result_t;

    // Handshake between the decode core and the stage registers
    typedef struct packed {
        logic advance;  // input beat is consumed this cycle
        logic emit;     // a result is written to the output register
    } core_ctl_t;

endpackage

### hdl/dpcm_up_in_reg.sv
module dpcm_up_in_reg (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic bit_value,
    input  logic advance,
    output logic s1_valid,
    output logic s1_bit
);

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_bit_reg;
    logic accept;

    // Stall only while a held beat cannot move on
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next = accept || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg <= bit_value;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_bit   = s1_bit_reg;

endmodule

### hdl/dpcm_up_core.sv
module dpcm_up_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dpcm_up_pkg::cfg_t        cfg,
    input  logic                     s1_valid,
    input  logic                     s1_bit,
    input  logic                     out_busy,
    output dpcm_up_pkg::core_ctl_t   ctl,
    output dpcm_up_pkg::result_t     result
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > dpcm_up_pkg::ROW_W) ? CW + 1 : dpcm_up_pkg::ROW_W;

    logic [CW-1:0]                     column_reg;
    logic [CW-1:0]                     column_next;
    logic [dpcm_up_pkg::RAW_CNT_W-1:0] raw_count_reg;
    logic [dpcm_up_pkg::RAW_CNT_W-1:0] raw_count_next;
    logic [dpcm_up_pkg::PIX_W-1:0]     raw_shift_reg;
    logic [dpcm_up_pkg::PIX_W-1:0]     raw_shift_next;
    logic [dpcm_up_pkg::RUN_W-1:0]     run_count_reg;
    logic [dpcm_up_pkg::RUN_W-1:0]     run_count_next;
    logic [dpcm_up_pkg::PIX_W-1:0]     prev_pixel_reg;
    logic [dpcm_up_pkg::PIX_W-1:0]     prev_pixel_next;

    logic [WW-1:0]                     eff_width;
    logic [WW-1:0]                     col_plus1;
    logic                              last;
    logic                              raw_phase;
    logic                              produces;
    logic [dpcm_up_pkg::RUN_W-1:0]     mag;
    logic [2*dpcm_up_pkg::PIX_W-1:0]   prod;
    logic [dpcm_up_pkg::PIX_W-1:0]     delta;
    logic [dpcm_up_pkg::PIX_W-1:0]     coded_pixel;
    logic [dpcm_up_pkg::PIX_W-1:0]     new_pixel;
    logic [dpcm_up_pkg::RAW_CNT_W-1:0] raw_count_inc;

    // Effective row width: zero acts as one, clamp at MAX_WIDTH
    always_comb
    begin
        if (cfg.row_width == '0)
        begin
            eff_width = WW'(1);
        end
        else if (WW'(cfg.row_width) > WW'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(cfg.row_width);
        end
    end

    assign col_plus1 = WW'(column_reg) + WW'(1);
    assign last      = (col_plus1 >= eff_width);
    assign raw_phase = (column_reg == '0);

    // Zigzag magnitude: odd run gives (k+1)/2, even run gives k/2
    assign mag   = run_count_reg[0] ? ((run_count_reg >> 1) + dpcm_up_pkg::RUN_W'(1))
                                    : (run_count_reg >> 1);
    assign prod  = mag * cfg.quant_step;
    assign delta = prod[dpcm_up_pkg::PIX_W-1:0];
    assign coded_pixel = run_count_reg[0] ? (prev_pixel_reg + delta)
                                          : (prev_pixel_reg - delta);

    assign raw_count_inc  = raw_count_reg + dpcm_up_pkg::RAW_CNT_W'(1);
    assign raw_shift_next = {raw_shift_reg[dpcm_up_pkg::PIX_W-2:0], s1_bit};

    // Does this beat complete a pixel
    always_comb
    begin
        if (raw_phase)
        begin
            produces = (raw_count_inc == dpcm_up_pkg::RAW_BITS);
        end
        else
        begin
            produces = !s1_bit;
        end
    end

    assign new_pixel = raw_phase ? raw_shift_next : coded_pixel;

    // Hold the beat only when a result is due and the output is full
    assign ctl.advance = s1_valid && !(produces && out_busy);
    assign ctl.emit    = ctl.advance && produces;

    assign result.pixel    = new_pixel;
    assign result.row_last = last;

    // Next state for one consumed bit
    always_comb
    begin
        column_next     = column_reg;
        raw_count_next  = raw_count_reg;
        run_count_next  = run_count_reg;
        prev_pixel_next = prev_pixel_reg;
        if (raw_phase)
        begin
            raw_count_next = raw_count_inc;
        end
        else if (s1_bit)
        begin
            if (run_count_reg != dpcm_up_pkg::RUN_MAX)
            begin
                run_count_next = run_count_reg + dpcm_up_pkg::RUN_W'(1);
            end
        end
        if (produces)
        begin
            raw_count_next  = '0;
            run_count_next  = '0;
            prev_pixel_next = new_pixel;
            column_next     = last ? '0 : col_plus1[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            raw_count_reg  <= '0;
            raw_shift_reg  <= '0;
            run_count_reg  <= '0;
            prev_pixel_reg <= '0;
        end
        else if (ctl.advance)
        begin
            column_reg     <= column_next;
            raw_count_reg  <= raw_count_next;
            run_count_reg  <= run_count_next;
            prev_pixel_reg <= prev_pixel_next;
            if (raw_phase)
            begin
                raw_shift_reg <= raw_shift_next;
            end
        end
    end

endmodule

### hdl/dpcm_up_out_reg.sv
module dpcm_up_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  dpcm_up_pkg::result_t                result,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                out_busy,
    output logic [dpcm_up_pkg::PIX_W-1:0]       pixel,
    output logic                                row_last
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    dpcm_up_pkg::result_t result_reg;

    // Full and not taken this cycle
    assign out_busy       = out_valid_reg && out_stall;
    assign out_valid_next = load || out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = result_reg.pixel;
    assign row_last  = result_reg.row_last;

endmodule

### hdl/dpcm_unary_pixel_decoder.sv
// Serial DPCM pixel decoder, one coded bit per input beat.
// Input channel: in_valid / in_stall carry bit_value. Output channel:
// out_valid / out_stall carry pixel and row_last, one beat per decoded pixel.
// The first pixel of a row is 8 raw bits, MSB first; later pixels are a run
// of ones closed by a zero, mapped zigzag to a residual scaled by quant_step.
// Configuration: cfg_wr_en / cfg_index / cfg_data write row_width (index 0)
// or quant_step (index 1); write only while the decoder is idle.
// Throughput: one bit per clock unless the input is stalled. Each bit sits
// in an input register; the run decode, 8x8 multiply and add then update
// the state. The bit that completes a pixel is held in the input register,
// then its result beat is loaded into the output register.
// Stall: a stalled output beat holds; bits that complete no pixel keep
// flowing, and the input stalls only when a new pixel is ready while the
// output register is still held.
// Reset: all decode state clears to column 0 with prev pixel 0;
// row_width returns to 512 and quant_step to 15. No clearing pass.
module dpcm_unary_pixel_decoder #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [dpcm_up_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dpcm_up_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  bit_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [dpcm_up_pkg::PIX_W-1:0]         pixel,
    output logic                                  row_last
);

    dpcm_up_pkg::cfg_t      cfg_reg;
    dpcm_up_pkg::cfg_t      cfg_next;
    dpcm_up_pkg::core_ctl_t ctl;
    dpcm_up_pkg::result_t   result;
    logic                   s1_valid;
    logic                   s1_bit;
    logic                   out_busy;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dpcm_up_pkg::REG_ROW_WIDTH:
                    cfg_next.row_width = cfg_data[dpcm_up_pkg::ROW_W-1:0];
                dpcm_up_pkg::REG_QUANT_STEP:
                    cfg_next.quant_step = cfg_data[dpcm_up_pkg::STEP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width  <= dpcm_up_pkg::ROW_WIDTH_RST;
            cfg_reg.quant_step <= dpcm_up_pkg::QUANT_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dpcm_up_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .bit_value (bit_value),
        .advance   (ctl.advance),
        .s1_valid  (s1_valid),
        .s1_bit    (s1_bit)
    );

    dpcm_up_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s1_valid (s1_valid),
        .s1_bit   (s1_bit),
        .out_busy (out_busy),
        .ctl      (ctl),
        .result   (result)
    );

    dpcm_up_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ctl.emit),
        .result    (result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_busy  (out_busy),
        .pixel     (pixel),
        .row_last  (row_last)
    );

`ifndef NO_ASSERTIONS
    // A result is only produced from a held input beat
    a_emit_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> s1_valid)
        else $error("result emitted without an input beat");

    // A held output beat is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_busy |-> !ctl.emit)
        else $error("output register overwritten while stalled");

    // Input stalls only when a held bit waits on a full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // An emitted result shows up on the output the next cycle
    a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> out_valid)
        else $error("emitted result not presented");
`endif

endmodule
